### rtl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types, codes and defaults for the pointer shape to BGRA converter.
// ----------------------------------------------------------------------------
package csb_pkg;

    // Default sizes of the raw store and the pointer image
    localparam int RAW_BYTES_DEF  = 16384;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Width of byte address arithmetic (row * pitch plus column offset)
    localparam int CALC_W = 28;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_SIZE     = 3'd4;

    // Shape types
    localparam logic [1:0] TYPE_MONO    = 2'd0;
    localparam logic [1:0] TYPE_COLOR   = 2'd1;
    localparam logic [1:0] TYPE_MASKED  = 2'd2;
    localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_SHAPE = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Byte constants
    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] MSB_MASK  = 8'h80;

    // Request word
    typedef struct packed {
        logic        kind;
        logic [13:0] byte_address;
        logic [7:0]  byte_value;
        logic [9:0]  pixel_x;
        logic [10:0] pixel_y;
    } req_t;

    // Response word
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [1:0] status;
    } rsp_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_ADDR,
        S_READ,
        S_FORM
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       mul_a;
        logic       mul_b;
        logic       addr;
        logic       rd_en;
        logic [1:0] rd_idx;
        logic       load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_read;
        logic reject;
        logic mono;
        logic short_data;
        logic out_free;
    } stat_t;

endpackage

### rtl/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Sequencer: accepts a word, steps address math, byte reads and pixel forming.
// ----------------------------------------------------------------------------
module csb_ctrl
    import csb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       last_byte;

    // State and byte counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Two bytes for a monochrome pixel, four for colour
    assign last_byte = stat.mono ? (cnt_reg == 2'd1) : (cnt_reg == 2'd3);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.rd_idx = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.req_read)
                    begin
                        state_next = S_MUL_A;
                    end
                end
            end
            S_MUL_A:
            begin
                cmd.mul_a = 1'b1;
                if (stat.reject)
                begin
                    state_next = S_FORM;
                end
                else if (stat.mono)
                begin
                    state_next = S_MUL_B;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                cnt_next   = 2'd0;
                state_next = S_READ;
            end
            S_READ:
            begin
                // Drop the reads when the raw data is too short
                if (stat.short_data)
                begin
                    state_next = S_FORM;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    if (last_byte)
                    begin
                        state_next = S_FORM;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            S_FORM:
            begin
                // Hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/csb_dp.sv
// ----------------------------------------------------------------------------
// csb_dp
// Datapath: config registers, raw byte store, address math, pixel forming.
// ----------------------------------------------------------------------------
module csb_dp
    import csb_pkg::*;
#(
    parameter int RAW_BYTES  = RAW_BYTES_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  req_t                  req_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data
);

    localparam int ADDR_W = $clog2(RAW_BYTES);

    // Configuration registers
    logic [1:0]  type_reg;
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [14:0] pitch_reg;
    logic [14:0] size_reg;

    // Working registers
    logic [9:0]        x_reg;
    logic [10:0]       y_reg;
    logic [1:0]        st_reg;
    logic [CALC_W-1:0] prod_a_reg;
    logic [CALC_W-1:0] prod_b_reg;
    logic [CALC_W-1:0] base_reg;
    logic [CALC_W-1:0] xor_reg;
    logic              short_reg;
    logic [7:0]        byte_reg [4];
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [7:0] mem [RAW_BYTES];

    logic              mono;
    logic [11:0]       vis_h;
    logic              bad;
    logic              outside;
    logic [1:0]        st_now;
    logic [11:0]       mul_op;
    logic [26:0]       product;
    logic [CALC_W-1:0] x_byte, x_quad, w_quad;
    logic [CALC_W-1:0] size_ext, eff_size;
    logic [CALC_W-1:0] and_sum, col_sum, xor_sum, row_end;
    logic [CALC_W-1:0] wr_ext, rd_addr;
    logic              wr_en;
    logic [7:0]        bit_mask;
    logic              a_bit, x_bit;
    rsp_t              pix;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg   <= TYPE_MONO;
            width_reg  <= '0;
            height_reg <= '0;
            pitch_reg  <= '0;
            size_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHAPE_TYPE:   type_reg   <= cfg_data[1:0];
                CFG_SHAPE_WIDTH:  width_reg  <= cfg_data[10:0];
                CFG_SHAPE_HEIGHT: height_reg <= cfg_data[11:0];
                CFG_ROW_PITCH:    pitch_reg  <= cfg_data;
                CFG_RAW_SIZE:     size_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Shape checks
    assign mono    = (type_reg == TYPE_MONO);
    assign vis_h   = mono ? {1'b0, height_reg[11:1]} : height_reg;
    assign bad     = (width_reg == '0) || (height_reg == '0)
                   || (width_reg > 11'(MAX_WIDTH)) || (height_reg > 12'(MAX_HEIGHT))
                   || (type_reg == TYPE_UNKNOWN) || (vis_h == '0);
    assign outside = ({1'b0, x_reg} >= width_reg) || ({1'b0, y_reg} >= vis_h);
    assign st_now  = bad ? STATUS_BAD_SHAPE : (outside ? STATUS_OUTSIDE : STATUS_OK);

    // Shared row multiplier: AND row, then XOR row half the raw height below
    assign mul_op  = cmd.mul_b ? ({1'b0, y_reg} + vis_h) : {1'b0, y_reg};
    assign product = mul_op * pitch_reg;

    // Byte offsets and store limit
    assign x_byte   = CALC_W'(x_reg[9:3]);
    assign x_quad   = CALC_W'({x_reg, 2'b00});
    assign w_quad   = CALC_W'({width_reg, 2'b00});
    assign size_ext = CALC_W'(size_reg);
    assign eff_size = (size_ext < CALC_W'(RAW_BYTES)) ? size_ext : CALC_W'(RAW_BYTES);
    assign and_sum  = prod_a_reg + x_byte;
    assign col_sum  = prod_a_reg + x_quad;
    assign xor_sum  = prod_b_reg + x_byte;
    assign row_end  = prod_a_reg + w_quad;

    // Advance the per-pixel working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg <= req_data.pixel_x;
            y_reg <= req_data.pixel_y;
        end
        if (cmd.mul_a)
        begin
            st_reg     <= st_now;
            prod_a_reg <= CALC_W'(product);
        end
        if (cmd.mul_b)
        begin
            prod_b_reg <= CALC_W'(product);
        end
        if (cmd.addr)
        begin
            base_reg  <= mono ? and_sum : col_sum;
            xor_reg   <= xor_sum;
            short_reg <= mono ? (xor_sum >= eff_size) : (row_end > eff_size);
        end
    end

    // Raw byte store: one write or one read per cycle
    assign wr_ext  = CALC_W'(req_data.byte_address);
    assign wr_en   = cmd.accept && (req_data.kind == KIND_WRITE)
                   && (wr_ext < CALC_W'(RAW_BYTES));
    assign rd_addr = (mono && (cmd.rd_idx == 2'd1)) ? xor_reg
                   : (base_reg + CALC_W'(cmd.rd_idx));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ext[ADDR_W-1:0]] <= req_data.byte_value;
        end
        if (cmd.rd_en)
        begin
            byte_reg[cmd.rd_idx] <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    // Form the pixel from the fetched bytes
    assign bit_mask = MSB_MASK >> x_reg[2:0];
    assign a_bit    = |(byte_reg[0] & bit_mask);
    assign x_bit    = |(byte_reg[1] & bit_mask);

    always_comb
    begin
        pix        = '0;
        pix.status = st_reg;
        if ((st_reg == STATUS_OK) && !short_reg)
        begin
            case (type_reg)
                TYPE_MONO:
                begin
                    if (!a_bit && x_bit)
                    begin
                        pix.blue  = BYTE_FULL;
                        pix.green = BYTE_FULL;
                        pix.red   = BYTE_FULL;
                        pix.alpha = BYTE_FULL;
                    end
                    else if (!(a_bit && !x_bit))
                    begin
                        pix.alpha = BYTE_FULL;
                    end
                end
                TYPE_COLOR:
                begin
                    pix.blue  = byte_reg[0];
                    pix.green = byte_reg[1];
                    pix.red   = byte_reg[2];
                    pix.alpha = byte_reg[3];
                end
                TYPE_MASKED:
                begin
                    pix.alpha = BYTE_FULL;
                    if (byte_reg[3] == BYTE_ZERO)
                    begin
                        pix.blue  = byte_reg[0];
                        pix.green = byte_reg[1];
                        pix.red   = byte_reg[2];
                    end
                end
                default:
                begin
                    pix = '0;
                end
            endcase
        end
    end

    // Output register: load a new word, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg <= pix;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Status to the controller
    assign stat.req_read   = (req_data.kind == KIND_READ);
    assign stat.reject     = bad || outside;
    assign stat.mono       = mono;
    assign stat.short_data = short_reg;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

### rtl/cursor_shape_to_bgra_core.sv
// ----------------------------------------------------------------------------
// cursor_shape_to_bgra_core
// A pixel read steps through S_MUL_A, S_MUL_B (monochrome only), S_ADDR, S_READ
// and S_FORM; a rejected read goes from S_MUL_A straight to S_FORM, and S_READ
// drops its byte reads on short data. One write per cycle is taken while idle; a read
// keeps the request side closed through these states, set by the single store port
// and the shared row multiplier, and S_FORM also waits for the output register to free.
// Reset clears control state and configuration registers; the raw store is not cleared.
// ----------------------------------------------------------------------------
module cursor_shape_to_bgra_core
    import csb_pkg::*;
#(
    parameter int RAW_BYTES  = RAW_BYTES_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    csb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csb_dp #(
        .RAW_BYTES  (RAW_BYTES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

### rtl/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks for the pointer shape converter, bound to the top level.
// ----------------------------------------------------------------------------
module csb_checker
    import csb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input req_t                  req_data,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input rsp_t                  rsp_data
);

    // A stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response word changed while stalled");

    // A byte write never produces a response word
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.kind == KIND_WRITE) && !rsp_valid
        |=> !rsp_valid)
        else $error("response after a byte write");

    // A pixel read keeps the request side closed while it is worked on
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.kind == KIND_READ) |=> !req_ready)
        else $error("request taken during a pixel read");

    // Rejected pixels carry zero colour, and the status is a known code
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != STATUS_OK)
        |-> ((rsp_data.status == STATUS_BAD_SHAPE) || (rsp_data.status == STATUS_OUTSIDE))
            && (rsp_data.blue == '0)
            && (rsp_data.green == '0) && (rsp_data.red == '0)
            && (rsp_data.alpha == '0))
        else $error("rejected pixel with colour or bad status");

endmodule

bind cursor_shape_to_bgra_core csb_checker u_csb_checker (.*);
